// ===== rtl/assert_macros.svh =====
// Assertion helpers sampled on clk_i. QRS_ASSERT is off while rst_ni is low,
// QRS_ASSERT_ALWAYS also checks during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define QRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define QRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/qrs_pkg.sv =====
`default_nettype none
package qrs_pkg;

  localparam int unsigned CoefW    = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned BandW    = 32;
  localparam logic [BandW-1:0] BandReset = 32'd4295;

  // discriminant magnitude, its floored root, root numerators and 2a
  localparam int unsigned DiscW = 2 * CoefW + 2;
  localparam int unsigned RootW = CoefW + 1;
  localparam int unsigned NumW  = CoefW + 3;
  localparam int unsigned DenW  = CoefW + 1;

  typedef enum logic [1:0] {
    CntNone = 2'd0,
    CntOne  = 2'd1,
    CntTwo  = 2'd2,
    CntInf  = 2'd3
  } count_e;

  typedef struct packed {
    logic signed [CoefW-1:0] coef_a;
    logic signed [CoefW-1:0] coef_b;
    logic signed [CoefW-1:0] coef_c;
  } qrs_in_t;

  typedef struct packed {
    count_e                  root_count;
    logic signed [CoefW-1:0] root_first;
    logic signed [CoefW-1:0] root_second;
    logic                    root_saturated;
  } qrs_out_t;

  // travels beside the square root
  typedef struct packed {
    logic signed [CoefW-1:0] coef_a;
    logic signed [CoefW-1:0] coef_b;
    logic signed [CoefW-1:0] coef_c;
    count_e                  root_count;
  } qrs_side_t;

  function automatic logic [CoefW-1:0] mag_coef(input logic signed [CoefW-1:0] v);
    return v[CoefW-1] ? CoefW'(-v) : CoefW'(v);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/quadratic_root_solver_core.sv =====
// Quadratic root solver: a*x^2 + b*x + c = 0 with signed Q16.16 coefficients.
// Command channel: coef_i is taken on a clock edge with start_i high and busy_o
// low. busy_o stays low, so a new coefficient set may enter on every cycle.
// Result channel: result_valid_o strobes for one cycle with result_o holding
// the root count code (none, one, two, infinitely many), the roots in Q16.16
// (zero when absent) and a saturation flag. The receiver has no way to stall.
// The path from the start beat to the result strobe is registered throughout:
// products and discriminant, the bit-per-stage square root, the numerator
// register, the bit-per-stage divider pair, and the output format register.
// Throughput is one item per cycle.
// Config: cfg_we_i writes cfg_wdata_i into the near-zero discriminant band
// (Q32.32 magnitude); write it only while the pipeline is empty.
// Reset clears all valid bits and restores the band to about 1e-6; items in
// flight at reset are dropped.
`default_nettype none
`include "assert_macros.svh"
module quadratic_root_solver_core #(
  parameter int unsigned FRAC_BITS = qrs_pkg::FracBits
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  output logic                           busy_o,
  input  wire qrs_pkg::qrs_in_t          coef_i,
  input  wire logic                      cfg_we_i,
  input  wire logic [qrs_pkg::BandW-1:0] cfg_wdata_i,
  output logic                           result_valid_o,
  output qrs_pkg::qrs_out_t              result_o
);
  localparam int unsigned W      = qrs_pkg::CoefW;
  localparam int unsigned NmW    = qrs_pkg::NumW;
  localparam int unsigned DnW    = qrs_pkg::DenW;
  localparam int unsigned SideW  = $bits(qrs_pkg::qrs_side_t);
  localparam int unsigned DivLat = W + 3;

  logic [qrs_pkg::BandW-1:0] band_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) band_q <= qrs_pkg::BandReset;
    else if (cfg_we_i) band_q <= cfg_wdata_i;
  end

  assign busy_o = 1'b0;

  logic                       dv;
  logic [qrs_pkg::DiscW-1:0]  drad;
  qrs_pkg::qrs_side_t         dside;

  qrs_disc u_disc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i && !busy_o),
    .coef_i  (coef_i),
    .band_i  (band_q),
    .valid_o (dv),
    .rad_o   (drad),
    .side_o  (dside)
  );

  logic                       sv;
  logic [qrs_pkg::RootW-1:0]  sroot;
  logic [SideW-1:0]           sside_vec;
  qrs_pkg::qrs_side_t         sside;

  qrs_sqrt #(.SIDE_W(SideW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dv),
    .rad_i   (drad),
    .side_i  (dside),
    .valid_o (sv),
    .root_o  (sroot),
    .side_o  (sside_vec)
  );

  assign sside = sside_vec;

  // numerator / denominator selection
  logic signed [NmW-1:0] bx, cx, sx;
  logic signed [NmW-1:0] n1_d, n2_d;
  logic signed [DnW-1:0] den_d;
  logic                  num_valid_q;
  logic signed [NmW-1:0] n1_q, n2_q;
  logic signed [DnW-1:0] den_q;
  logic [1:0]            ncode_q;

  assign bx = {{3{sside.coef_b[W-1]}}, sside.coef_b};
  assign cx = {{3{sside.coef_c[W-1]}}, sside.coef_c};
  assign sx = {2'b00, sroot};

  always_comb begin
    n1_d  = '0;
    n2_d  = '0;
    den_d = '0;
    case (sside.root_count)
      qrs_pkg::CntOne: begin
        if (sside.coef_a == '0) begin
          n1_d  = -cx;
          den_d = {sside.coef_b[W-1], sside.coef_b};
        end else begin
          n1_d  = -bx;
          den_d = {sside.coef_a, 1'b0};
        end
      end
      qrs_pkg::CntTwo: begin
        n1_d  = -bx - sx;
        n2_d  = -bx + sx;
        den_d = {sside.coef_a, 1'b0};
      end
      default: begin
        n1_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) num_valid_q <= 1'b0;
    else num_valid_q <= sv;
  end

  always_ff @(posedge clk_i) begin
    n1_q    <= n1_d;
    n2_q    <= n2_d;
    den_q   <= den_d;
    ncode_q <= sside.root_count;
  end

  logic         qv;
  logic [W-1:0] q1, q2;
  logic         qs1, qs2;
  logic [1:0]   qcode;

  qrs_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(2)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (num_valid_q),
    .num1_i  (n1_q),
    .num2_i  (n2_q),
    .den_i   (den_q),
    .side_i  (ncode_q),
    .valid_o (qv),
    .quot1_o (q1),
    .quot2_o (q2),
    .sat1_o  (qs1),
    .sat2_o  (qs2),
    .side_o  (qcode)
  );

  // output register
  logic              res_valid_q;
  qrs_pkg::qrs_out_t res_q, res_d;
  qrs_pkg::count_e   code;

  assign code = qrs_pkg::count_e'(qcode);

  always_comb begin
    res_d.root_count     = code;
    res_d.root_first     = '0;
    res_d.root_second    = '0;
    res_d.root_saturated = 1'b0;
    case (code)
      qrs_pkg::CntOne: begin
        res_d.root_first     = q1;
        res_d.root_saturated = qs1;
      end
      qrs_pkg::CntTwo: begin
        res_d.root_first     = q1;
        res_d.root_second    = q2;
        res_d.root_saturated = qs1 | qs2;
      end
      default: begin
        res_d.root_saturated = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_valid_q <= 1'b0;
    else res_valid_q <= qv;
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  logic res_absent, res_one, roots_clear;

  assign res_absent  = result_o.root_count == qrs_pkg::CntNone ||
                       result_o.root_count == qrs_pkg::CntInf;
  assign res_one     = result_o.root_count == qrs_pkg::CntOne;
  assign roots_clear = result_o.root_first == '0 && result_o.root_second == '0 &&
                       !result_o.root_saturated;

  `QRS_ASSERT(a_absent_zero, result_valid_o && res_absent |-> roots_clear, "absent roots not zero")
  `QRS_ASSERT(a_one_second, result_valid_o && res_one |-> result_o.root_second == '0, "second set")
  `QRS_ASSERT(a_div_latency, result_valid_o |-> $past(num_valid_q, DivLat), "orphan result beat")
  `QRS_ASSERT_ALWAYS(a_never_busy, !busy_o, "busy raised")

endmodule
`default_nettype wire

// ===== rtl/qrs_disc.sv =====
`default_nettype none
module qrs_disc (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  input  wire qrs_pkg::qrs_in_t             coef_i,
  input  wire logic [qrs_pkg::BandW-1:0]    band_i,
  output logic                              valid_o,
  output logic [qrs_pkg::DiscW-1:0]         rad_o,
  output qrs_pkg::qrs_side_t                side_o
);
  localparam int unsigned W  = qrs_pkg::CoefW;
  localparam int unsigned DW = qrs_pkg::DiscW;

  // stage 1: products
  logic             v1_q;
  qrs_pkg::qrs_in_t in1_q;
  logic [2*W-1:0]   bb_q, ac_q;
  logic             add1_q;
  logic [W-1:0]     mb, ma, mc;
  logic [2*W-1:0]   bb_d, ac_d;

  assign mb   = qrs_pkg::mag_coef(coef_i.coef_b);
  assign ma   = qrs_pkg::mag_coef(coef_i.coef_a);
  assign mc   = qrs_pkg::mag_coef(coef_i.coef_c);
  assign bb_d = mb * mb;
  assign ac_d = ma * mc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    in1_q  <= coef_i;
    bb_q   <= bb_d;
    ac_q   <= ac_d;
    add1_q <= (coef_i.coef_a[W-1] != coef_i.coef_c[W-1]) || (coef_i.coef_c == '0);
  end

  // stage 2: magnitude and sign of b*b - 4ac
  logic             v2_q;
  qrs_pkg::qrs_in_t in2_q;
  logic [DW-1:0]    d2_q, d2_d, ac4, bbx;
  logic             dneg2_q, dneg2_d;

  assign ac4 = {ac_q, 2'b00};
  assign bbx = {2'b00, bb_q};

  always_comb begin
    dneg2_d = 1'b0;
    if (add1_q) begin
      d2_d = bbx + ac4;
    end else if (bbx < ac4) begin
      d2_d    = ac4 - bbx;
      dneg2_d = 1'b1;
    end else begin
      d2_d = bbx - ac4;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    in2_q   <= in1_q;
    d2_q    <= d2_d;
    dneg2_q <= dneg2_d;
  end

  // stage 3: classify against the band
  logic              v3_q;
  logic [DW-1:0]     band_x;
  logic              in_band;
  qrs_pkg::count_e   code_d;
  qrs_pkg::qrs_side_t side_q;
  logic [DW-1:0]     rad_q;

  assign band_x  = {(DW - qrs_pkg::BandW)'(0), band_i};
  assign in_band = d2_q < band_x;

  always_comb begin
    if (in2_q.coef_a == '0) begin
      if (in2_q.coef_b == '0) code_d = (in2_q.coef_c == '0) ? qrs_pkg::CntInf : qrs_pkg::CntNone;
      else code_d = qrs_pkg::CntOne;
    end else if (!dneg2_q && !in_band) begin
      code_d = qrs_pkg::CntTwo;
    end else if (in_band) begin
      code_d = qrs_pkg::CntOne;
    end else begin
      code_d = qrs_pkg::CntNone;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    rad_q             <= d2_q;
    side_q.coef_a     <= in2_q.coef_a;
    side_q.coef_b     <= in2_q.coef_b;
    side_q.coef_c     <= in2_q.coef_c;
    side_q.root_count <= code_d;
  end

  assign valid_o = v3_q;
  assign rad_o   = rad_q;
  assign side_o  = side_q;

endmodule
`default_nettype wire

// ===== rtl/qrs_sqrt.sv =====
`default_nettype none
module qrs_sqrt #(
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  input  wire logic [qrs_pkg::DiscW-1:0]   rad_i,
  input  wire logic [SIDE_W-1:0]           side_i,
  output logic                             valid_o,
  output logic [qrs_pkg::RootW-1:0]        root_o,
  output logic [SIDE_W-1:0]                side_o
);
  localparam int unsigned RW   = qrs_pkg::RootW;
  localparam int unsigned DW   = qrs_pkg::DiscW;
  localparam int unsigned RemW = RW + 2;

  logic              valid_q [RW];
  logic [DW-1:0]     rad_q   [RW];
  logic [RemW-1:0]   rem_q   [RW];
  logic [RW-1:0]     root_q  [RW];
  logic [SIDE_W-1:0] side_q  [RW];

  // one root bit per stage, two radicand bits shifted in
  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic              vin;
    logic [DW-1:0]     rin;
    logic [RemW-1:0]   remin;
    logic [RW-1:0]     rootin;
    logic [SIDE_W-1:0] sin;
    logic [RemW+1:0]   cur, trial;
    logic              take;

    if (k == 0) begin : g_first
      assign vin    = valid_i;
      assign rin    = rad_i;
      assign remin  = '0;
      assign rootin = '0;
      assign sin    = side_i;
    end else begin : g_next
      assign vin    = valid_q[k-1];
      assign rin    = rad_q[k-1];
      assign remin  = rem_q[k-1];
      assign rootin = root_q[k-1];
      assign sin    = side_q[k-1];
    end

    assign cur   = {remin, rin[DW-1 -: 2]};
    assign trial = {2'b00, rootin, 2'b01};
    assign take  = cur >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) valid_q[k] <= 1'b0;
      else valid_q[k] <= vin;
    end

    always_ff @(posedge clk_i) begin
      rad_q[k]  <= rin << 2;
      rem_q[k]  <= take ? RemW'(cur - trial) : RemW'(cur);
      root_q[k] <= {rootin[RW-2:0], take};
      side_q[k] <= sin;
    end
  end

  assign valid_o = valid_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign side_o  = side_q[RW-1];

endmodule
`default_nettype wire

// ===== rtl/qrs_div.sv =====
`default_nettype none
module qrs_div #(
  parameter int unsigned FRAC_BITS = qrs_pkg::FracBits,
  parameter int unsigned SIDE_W    = 1
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              valid_i,
  input  wire logic signed [qrs_pkg::NumW-1:0]   num1_i,
  input  wire logic signed [qrs_pkg::NumW-1:0]   num2_i,
  input  wire logic signed [qrs_pkg::DenW-1:0]   den_i,
  input  wire logic [SIDE_W-1:0]                 side_i,
  output logic                                   valid_o,
  output logic [qrs_pkg::CoefW-1:0]              quot1_o,
  output logic [qrs_pkg::CoefW-1:0]              quot2_o,
  output logic                                   sat1_o,
  output logic                                   sat2_o,
  output logic [SIDE_W-1:0]                      side_o
);
  localparam int unsigned W    = qrs_pkg::CoefW;
  localparam int unsigned NmW  = qrs_pkg::NumW;
  localparam int unsigned MagW = NmW - 1;
  localparam int unsigned DnW  = qrs_pkg::DenW;
  localparam int unsigned NW   = MagW + FRAC_BITS;
  localparam int unsigned HiW  = NW - W;
  localparam int unsigned RemW = DnW + 1;
  localparam int unsigned CmpW = HiW + RemW;

  logic signed [NmW-1:0] num_in [2];
  assign num_in[0] = num1_i;
  assign num_in[1] = num2_i;

  logic [DnW-1:0] dm_d;
  assign dm_d = den_i[DnW-1] ? DnW'(-den_i) : DnW'(den_i);

  // front stage: magnitudes, signs, overflow precheck
  logic              fv_q;
  logic [DnW-1:0]    fdm_q;
  logic [SIDE_W-1:0] fside_q;
  logic              fneg_q [2];
  logic              fovf_q [2];
  logic [DnW-1:0]    frem_q [2];
  logic [W-1:0]      flow_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fv_q <= 1'b0;
    else fv_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    fdm_q   <= dm_d;
    fside_q <= side_i;
  end

  for (genvar j = 0; j < 2; j++) begin : g_front
    logic [MagW-1:0] nm;
    logic [NW-1:0]   nsh;
    logic [HiW-1:0]  hi;
    assign nm  = num_in[j][NmW-1] ? MagW'(-num_in[j]) : MagW'(num_in[j]);
    assign nsh = {nm, FRAC_BITS'(0)};
    assign hi  = nsh[NW-1:W];
    always_ff @(posedge clk_i) begin
      fneg_q[j] <= num_in[j][NmW-1] ^ den_i[DnW-1];
      fovf_q[j] <= CmpW'(hi) >= CmpW'(dm_d);
      frem_q[j] <= DnW'(hi);
      flow_q[j] <= nsh[W-1:0];
    end
  end

  // quotient stages: dividend bits shift out of low, quotient bits shift in
  logic              v_q    [W];
  logic [DnW-1:0]    dm_q   [W];
  logic [SIDE_W-1:0] side_q [W];
  logic              neg_q  [W][2];
  logic              ovf_q  [W][2];
  logic [DnW-1:0]    rem_q  [W][2];
  logic [W-1:0]      low_q  [W][2];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic              vin;
    logic [DnW-1:0]    dmin;
    logic [SIDE_W-1:0] sin;

    if (k == 0) begin : g_first
      assign vin  = fv_q;
      assign dmin = fdm_q;
      assign sin  = fside_q;
    end else begin : g_next
      assign vin  = v_q[k-1];
      assign dmin = dm_q[k-1];
      assign sin  = side_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[k] <= 1'b0;
      else v_q[k] <= vin;
    end

    always_ff @(posedge clk_i) begin
      dm_q[k]   <= dmin;
      side_q[k] <= sin;
    end

    for (genvar j = 0; j < 2; j++) begin : g_lane
      logic           negin, ovfin;
      logic [DnW-1:0] remin;
      logic [W-1:0]   lowin;
      logic [RemW-1:0] r;
      logic           take;

      if (k == 0) begin : g_first
        assign negin = fneg_q[j];
        assign ovfin = fovf_q[j];
        assign remin = frem_q[j];
        assign lowin = flow_q[j];
      end else begin : g_next
        assign negin = neg_q[k-1][j];
        assign ovfin = ovf_q[k-1][j];
        assign remin = rem_q[k-1][j];
        assign lowin = low_q[k-1][j];
      end

      assign r    = {remin, lowin[W-1]};
      assign take = r >= {1'b0, dmin};

      always_ff @(posedge clk_i) begin
        neg_q[k][j] <= negin;
        ovf_q[k][j] <= ovfin;
        rem_q[k][j] <= take ? DnW'(r - {1'b0, dmin}) : DnW'(r);
        low_q[k][j] <= {lowin[W-2:0], take};
      end
    end
  end

  // final stage: clamp and apply sign
  logic              ov_q;
  logic [SIDE_W-1:0] oside_q;
  logic [W-1:0]      oq_q  [2];
  logic              osat_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else ov_q <= v_q[W-1];
  end

  always_ff @(posedge clk_i) begin
    oside_q <= side_q[W-1];
  end

  for (genvar j = 0; j < 2; j++) begin : g_out
    logic [W-1:0] q, lim, res;
    logic         sat;
    assign q   = low_q[W-1][j];
    assign lim = neg_q[W-1][j] ? {1'b1, (W-1)'(0)} : {1'b0, {(W-1){1'b1}}};
    assign sat = ovf_q[W-1][j] || (q > lim);
    assign res = sat ? lim : q;
    always_ff @(posedge clk_i) begin
      oq_q[j]   <= neg_q[W-1][j] ? W'(-res) : res;
      osat_q[j] <= sat;
    end
  end

  assign valid_o = ov_q;
  assign quot1_o = oq_q[0];
  assign quot2_o = oq_q[1];
  assign sat1_o  = osat_q[0];
  assign sat2_o  = osat_q[1];
  assign side_o  = oside_q;

endmodule
`default_nettype wire

// ===== sim/qrs_root_checker.sv =====
`default_nettype none
module qrs_root_checker (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic                      busy_i,
  input  wire qrs_pkg::qrs_in_t          coef_i,
  input  wire logic                      cfg_we_i,
  input  wire logic [qrs_pkg::BandW-1:0] cfg_wdata_i,
  input  wire logic                      result_valid_i,
  input  wire qrs_pkg::qrs_out_t         result_i,
  output int                             errors_o,
  output int                             pending_o,
  output int                             roots_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import qrs_pkg::*;

  logic [BandW-1:0] band_q;
  qrs_out_t roots_q[$];

  // trunc(num * 2^16 / den), clamped to the signed 32-bit range
  function automatic logic [31:0] fx_quot(input logic signed [127:0] num,
                                          input logic signed [127:0] den,
                                          inout logic sat);
    logic signed [127:0] q;
    q = (num <<< FracBits) / den;
    if (q > 128'sd2147483647) begin
      sat = 1'b1;
      q = 128'sd2147483647;
    end else if (q < -128'sd2147483648) begin
      sat = 1'b1;
      q = -128'sd2147483648;
    end
    return q[31:0];
  endfunction

  function automatic logic [127:0] floor_sqrt(input logic [127:0] v);
    logic [127:0] r, t;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (128'd1 << i);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic qrs_out_t solve_roots(input qrs_in_t in, input logic [BandW-1:0] band);
    qrs_out_t o;
    logic signed [127:0] a, b, c, d, s;
    logic sat;
    a = in.coef_a;
    b = in.coef_b;
    c = in.coef_c;
    o = '0;
    sat = 1'b0;
    o.root_count = CntNone;
    if (a == 0) begin
      if (b == 0) o.root_count = (c == 0) ? CntInf : CntNone;
      else begin
        o.root_count = CntOne;
        o.root_first = fx_quot(-c, b, sat);
      end
    end else begin
      d = b * b - 4 * a * c;
      if (d >= $signed({96'd0, band})) begin
        s = floor_sqrt(d);
        o.root_count = CntTwo;
        o.root_first = fx_quot(-b - s, 2 * a, sat);
        o.root_second = fx_quot(-b + s, 2 * a, sat);
      end else if (d > -$signed({96'd0, band})) begin
        o.root_count = CntOne;
        o.root_first = fx_quot(-b, 2 * a, sat);
      end
    end
    o.root_saturated = sat;
    return o;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    qrs_out_t exp_r;
    if (!rst_ni) begin
      band_q <= BandReset;
      errors_o <= 0;
      roots_seen_o <= 0;
    end else begin
      if (cfg_we_i) band_q <= cfg_wdata_i;
      if (start_i && !busy_i) roots_q.push_back(solve_roots(coef_i, band_q));
      if (result_valid_i) begin
        roots_seen_o <= roots_seen_o + 1;
        if (roots_q.size() == 0) begin
          $display("%t unexpected beat: got %h", $realtime, result_i);
          errors_o <= errors_o + 1;
        end else begin
          exp_r = roots_q.pop_front();
          if (exp_r !== result_i) begin
            $display("%t mismatch: expected cnt=%0d r1=%h r2=%h sat=%b, got cnt=%0d r1=%h r2=%h sat=%b",
                     $realtime, exp_r.root_count, exp_r.root_first, exp_r.root_second,
                     exp_r.root_saturated, result_i.root_count, result_i.root_first,
                     result_i.root_second, result_i.root_saturated);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = roots_q.size();
endmodule
`default_nettype wire

// ===== sim/tb_quadratic_root_solver_core.sv =====
`default_nettype none
module tb_quadratic_root_solver_core;
  timeunit 1ns;
  timeprecision 1ps;
  import qrs_pkg::*;

  localparam int Latency = 72;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  qrs_in_t coef_i = '0;
  logic cfg_we_i = 1'b0;
  logic [BandW-1:0] cfg_wdata_i = '0;
  logic result_valid_o;
  qrs_out_t result_o;
  int errors, pending, roots_seen;
  int idle_pct;
  int sent;

  quadratic_root_solver_core u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .coef_i, .cfg_we_i, .cfg_wdata_i,
    .result_valid_o, .result_o
  );

  qrs_root_checker u_chk (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .coef_i, .cfg_we_i, .cfg_wdata_i,
    .result_valid_i(result_valid_o), .result_i(result_o),
    .errors_o(errors), .pending_o(pending), .roots_seen_o(roots_seen)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("FAIL quadratic_root_solver_core");
    $finish;
  end

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3, 4: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      5: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // one beat, with optional idle cycles ahead of it
  task automatic send_coefs(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    coef_i <= '{coef_a: a, coef_b: b, coef_c: c};
    do @(posedge clk_i); while (busy_o);
    sent++;
  endtask

  task automatic write_band(input logic [BandW-1:0] v);
    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [31:0] a, b, r1, r2;
    idle_pct = 0;
    sent = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: linear/degenerate, double root, band edges, overflow
    send_coefs(0, 0, 0);
    send_coefs(0, 0, 32'h0001_0000);
    send_coefs(0, 32'h0001_0000, 32'h0003_0000);
    send_coefs(0, 32'hffff_0000, 32'h8000_0000);
    send_coefs(0, 1, 32'h7fff_ffff);
    send_coefs(32'h0001_0000, 32'hfffe_0000, 32'h0001_0000);
    send_coefs(32'h0001_0000, 0, 32'hffff_0000);
    send_coefs(32'h0001_0000, 0, 32'h0001_0000);
    send_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_coefs(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_coefs(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_coefs(1, 32'h7fff_ffff, 0);
    send_coefs(1, 0, 0);
    send_coefs(32'hffff_ffff, 32'h8000_0000, 1);
    send_coefs(32'h0000_0100, 32'h0000_0002, 32'h0000_0003);
    send_coefs(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
    write_band(0);
    send_coefs(32'h0001_0000, 32'hfffe_0000, 32'h0001_0000);
    send_coefs(32'h0000_0001, 32'h0000_0002, 32'h0000_0001);
    send_coefs(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 0) ? 0 : (phase == 2) ? 14 : 54;
      case (phase)
        0: write_band(32'hffff_ffff);
        1: write_band(BandReset);
        2: write_band($urandom);
        default: write_band($urandom_range(0, 65535));
      endcase
      for (int n = 0; n < 275; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          // built from chosen roots so the discriminant lands near the band
          a = $urandom_range(1, 32'h0002_0000);
          r1 = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
          r2 = ($urandom_range(0, 1) == 1) ? r1 : r1 + $urandom_range(0, 16);
          b = 32'(-((64'($signed(a)) * (64'($signed(r1)) + 64'($signed(r2)))) >>> 16));
          send_coefs(a, b,
                     32'((((64'($signed(a)) * 64'($signed(r1))) >>> 16) * 64'($signed(r2)))
                         >>> 16));
        end else begin
          send_coefs(pick_coef(), pick_coef(), pick_coef());
        end
      end
    end
    start_i <= 1'b0;

    fork
      begin
        while (pending != 0) @(posedge clk_i);
        repeat (Latency + 10) @(posedge clk_i);
      end
      begin
        repeat (200000) @(posedge clk_i);
        $display("FAIL quadratic_root_solver_core");
        $finish;
      end
    join_any
    $display("Ran %0d coefficient sets over four band settings and idle mixes; %0d results checked.",
             sent, roots_seen);
    if (errors == 0 && pending == 0) begin
      $display("PASS quadratic_root_solver_core");
    end else begin
      $display("FAIL quadratic_root_solver_core");
    end
    $finish;
  end
endmodule
`default_nettype wire
